// ===== hdl/grc_pkg.sv =====
`default_nettype none

package grc_pkg;

    // Input operand width
    localparam int IW      = 16;
    // Output width and Q2.14 unity
    localparam int OW      = 16;
    localparam int FRAC_W  = 14;
    // Magnitude of one output, 0..2^FRAC_W
    localparam int MW      = FRAC_W + 1;
    // Squares and sum of squares
    localparam int SQ_W    = 2 * IW;
    localparam int RSQ_W   = 2 * IW + 1;
    // Accumulators hold x^2 scaled by 2^(2*FRAC_W+2)
    localparam int ACC_W   = 2 * IW + 2 * FRAC_W + 4;
    // Number of digit stages
    localparam int NSTEP   = MW;

    typedef struct packed {
        logic signed [IW-1:0] first_value;
        logic signed [IW-1:0] second_value;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] cosine;
        logic signed [OW-1:0] sine;
    } t_out;

    // Running state of one digit search lane
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;   // rsq * (2m-1)^2
        logic signed [ACC_W-1:0] lin;   // rsq * (2m-1) * 2^(k+2)
        logic signed [ACC_W-1:0] sq;    // rsq * 2^(2k+2)
        logic signed [ACC_W-1:0] lim;   // x^2 * 2^(2*FRAC_W+2)
        logic [MW-1:0]           mag;
    } t_lane;

    typedef struct packed {
        t_lane         c;
        t_lane         s;
        logic [MW-1:0] digit;  // one-hot bit under test
        logic          zero_b;
        logic          neg_c;
        logic          neg_s;
    } t_item;

    // One digit of round(2^FRAC_W * x / r)
    function automatic t_lane lane_step(input t_lane l, input logic [MW-1:0] digit);
        logic signed [ACC_W-1:0] cand;
        t_lane                   o;
        cand = l.acc + l.lin + l.sq;
        o    = l;
        if (cand <= l.lim) begin
            o.acc = cand;
            o.lin = l.lin + (l.sq <<< 1);
            o.mag = l.mag | digit;
        end
        o.lin = o.lin >>> 1;
        o.sq  = l.sq >>> 2;
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/grc_prep.sv =====
`default_nettype none

module grc_prep (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  grc_pkg::t_in     i_in,
    output logic             o_valid,
    output grc_pkg::t_item   o_item
);
    import grc_pkg::*;

    logic          r_v1;
    logic [IW-1:0] r_ma, r_mb;
    logic [SQ_W-1:0] r_sqa, r_sqb;
    logic          r_na, r_nb;
    logic [IW-1:0] n_ma, n_mb;
    logic          r_v2;
    t_item         r_item, n_item;
    logic [RSQ_W-1:0] rsq;

    // Magnitudes, exact also for the most negative input
    always_comb begin
        n_ma = i_in.first_value[IW-1]  ? (~i_in.first_value + 1'b1)  : i_in.first_value;
        n_mb = i_in.second_value[IW-1] ? (~i_in.second_value + 1'b1) : i_in.second_value;
    end

    // Stage 1: magnitudes and squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_na  <= i_in.first_value[IW-1];
        r_nb  <= i_in.second_value[IW-1];
        r_sqa <= SQ_W'(n_ma) * SQ_W'(n_ma);
        r_sqb <= SQ_W'(n_mb) * SQ_W'(n_mb);
    end

    // Stage 2: sum of squares and initial lane state
    always_comb begin
        rsq            = RSQ_W'(r_sqa) + RSQ_W'(r_sqb);
        n_item.c.acc   = ACC_W'(rsq);
        n_item.c.lin   = -(ACC_W'(rsq) <<< (FRAC_W + 2));
        n_item.c.sq    = ACC_W'(rsq) <<< (2 * FRAC_W + 2);
        n_item.c.lim   = ACC_W'(r_sqa) <<< (2 * FRAC_W + 2);
        n_item.c.mag   = '0;
        n_item.s       = n_item.c;
        n_item.s.lim   = ACC_W'(r_sqb) <<< (2 * FRAC_W + 2);
        n_item.digit   = MW'(1) << (MW - 1);
        n_item.zero_b  = (r_mb == '0);
        n_item.neg_c   = (r_mb > r_ma) && (r_na == r_nb);
        n_item.neg_s   = !(r_mb > r_ma) && (r_na == r_nb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_item <= n_item;
    end

    assign o_valid = r_v2;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/grc_step.sv =====
`default_nettype none

module grc_step (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  grc_pkg::t_item   i_item,
    output logic             o_valid,
    output grc_pkg::t_item   o_item
);
    import grc_pkg::*;

    logic  r_valid;
    t_item r_item, n_item;

    // Decide one output bit for both lanes
    always_comb begin
        n_item       = i_item;
        n_item.c     = lane_step(i_item.c, i_item.digit);
        n_item.s     = lane_step(i_item.s, i_item.digit);
        n_item.digit = i_item.digit >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/givens_rotation_coefficients_top.sv =====
// Throughput: one transaction per cycle; busy is always low.
// Two setup stages, one stage per result bit (15), one output stage.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset (synchronous, active low) clears all valid bits in flight.
`default_nettype none

module givens_rotation_coefficients_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  grc_pkg::t_in     i_in,
    output logic             busy,
    output logic             o_done,
    output grc_pkg::t_out    o_out
);
    import grc_pkg::*;

    logic  v   [0:NSTEP];
    t_item itm [0:NSTEP];
    logic  r_done;
    t_out  r_out, n_out;

    assign busy = 1'b0;

    grc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_in    (i_in),
        .o_valid (v[0]),
        .o_item  (itm[0])
    );

    // Digit pipeline, most significant bit first
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        grc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .i_item  (itm[k]),
            .o_valid (v[k+1]),
            .o_item  (itm[k+1])
        );
    end

    // Sign and zero-b override
    always_comb begin
        if (itm[NSTEP].zero_b) begin
            n_out.cosine = OW'(1) <<< FRAC_W;
            n_out.sine   = '0;
        end else begin
            n_out.cosine = itm[NSTEP].neg_c ? -OW'(itm[NSTEP].c.mag) : OW'(itm[NSTEP].c.mag);
            n_out.sine   = itm[NSTEP].neg_s ? -OW'(itm[NSTEP].s.mag) : OW'(itm[NSTEP].s.mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= v[NSTEP];
        end
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.cosine <= 16'sd16384) && (o_out.cosine >= -16'sd16384))
        else $error("cosine out of range");
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.sine <= 16'sd16384) && (o_out.sine >= -16'sd16384))
        else $error("sine out of range");
    a_not_both_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.cosine != '0) || (o_out.sine != '0))
        else $error("rotation with zero cosine and sine");
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[NSTEP] |=> o_done)
        else $error("result lost at output stage");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import grc_pkg::*;

    localparam int LATENCY   = 18;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1250;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_in   i_in;
    logic  busy;
    logic  o_done;
    t_out  o_out;

    t_out  expected_coeffs[$];
    int    n_errors;
    int    idle_cycles;

    givens_rotation_coefficients_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // round(16384 * x / sqrt(rsq)) by exact search on squares, ties upward
    function automatic logic [15:0] scaled_mag(input logic [15:0] x, input logic [32:0] rsq);
        logic [15:0]  lo;
        logic [15:0]  hi;
        logic [15:0]  mid;
        logic [127:0] lhs;
        logic [127:0] rhs;
        lo  = 16'd0;
        hi  = 16'd16384;
        rhs = (128'(x) * 128'(x)) << 30;
        while (lo < hi) begin
            mid = (lo + hi + 16'd1) >> 1;
            lhs = 128'(rsq) * (128'(2 * mid - 1) * 128'(2 * mid - 1));
            if (lhs <= rhs) lo = mid;
            else hi = mid - 16'd1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] apply_sign(input logic [15:0] mag, input logic neg);
        return (neg && mag != 0) ? -mag : mag;
    endfunction

    // Expected cosine/sine for one operand pair
    function automatic t_out rotation_coeffs(input t_in v);
        logic        na;
        logic        nb;
        logic [15:0] ma;
        logic [15:0] mb;
        logic [32:0] rsq;
        t_out        r;
        na = v.first_value[IW-1];
        nb = v.second_value[IW-1];
        ma = na ? 16'(-v.first_value) : 16'(v.first_value);
        mb = nb ? 16'(-v.second_value) : 16'(v.second_value);
        if (mb == 0) begin
            r.cosine = 16'sd16384;
            r.sine   = 16'sd0;
            return r;
        end
        rsq = 33'(ma) * 33'(ma) + 33'(mb) * 33'(mb);
        r.cosine = apply_sign(scaled_mag(ma, rsq), (mb > ma) && (na == nb));
        r.sine   = apply_sign(scaled_mag(mb, rsq), (mb <= ma) && (na == nb));
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // Send one transaction, then idle for the requested number of cycles
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input int gap);
        t_in v;
        v.first_value  = a;
        v.second_value = b;
        start <= 1'b1;
        i_in  <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_coeffs.push_back(rotation_coeffs(v));
        if (gap > 0) begin
            start <= 1'b0;
            i_in  <= t_in'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_out e;
            if (expected_coeffs.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                e = expected_coeffs.pop_front();
                if (o_out.cosine !== e.cosine)
                    report_mismatch($sformatf("cosine got %0d exp %0d",
                                              o_out.cosine, e.cosine));
                if (o_out.sine !== e.sine)
                    report_mismatch($sformatf("sine got %0d exp %0d",
                                              o_out.sine, e.sine));
            end
        end
    end

    // Watchdog on cycles with no accepted transaction and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        logic [15:0] vals[8];
        vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff,
                 16'h0003, 16'hfffd, 16'h4000};
        // zero b, equal magnitudes, most negative inputs, sign mixes
        send_pair(16'h0000, 16'h0000, 0);
        send_pair(16'h8000, 16'h8000, 0);
        send_pair(16'h7fff, 16'h8001, 1);
        send_pair(16'h8000, 16'h0000, 0);
        send_pair(16'h0000, 16'h8000, 0);
        send_pair(16'h0000, 16'h7fff, 2);
        send_pair(16'h0005, 16'hfffb, 0);
        for (int k = 0; k < 16; k++)
            send_pair(vals[$urandom_range(7)], vals[$urandom_range(7)], k % 3);
    endtask

    task automatic test_random();
        logic [15:0] a;
        logic [15:0] b;
        int          mode;
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(9);
            a = 16'($urandom);
            b = 16'($urandom);
            case (mode)
                0: b = 16'h0000;
                1: b = (a[0]) ? a : -a;
                2: begin
                    a = 16'($urandom_range(15));
                    b = 16'($urandom_range(15)) - 16'd8;
                end
                3: a = 16'h8000;
                default: ;
            endcase
            send_pair(a, b, (n % 200 < 30) ? 0 : gap_len());
        end
    endtask

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (expected_coeffs.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (n_errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/grc_pkg.sv
hdl/grc_prep.sv
hdl/grc_step.sv
hdl/givens_rotation_coefficients_top.sv
verif/tb_top.sv
